// ----- hdl/lru_page_buffer_pool_unit_macros.svh -----
// Assertion macros shared by the page buffer pool RTL
`ifndef LRU_PAGE_BUFFER_POOL_UNIT_MACROS_SVH
`define LRU_PAGE_BUFFER_POOL_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define LPB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lpb assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define LPB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lpb assertion failed");

`endif

// ----- hdl/lpb_pkg.sv -----
// Shared types and codes of the page buffer pool
package lpb_pkg;
	localparam int FRAME_W = 4;
	localparam int RANK_W = 4;
	localparam int CFG_W = 5;
	localparam int ADDR_LIMIT = 16;

	localparam logic [1:0] KIND_OPEN = 2'd0;
	localparam logic [1:0] KIND_UNPIN = 2'd1;
	localparam logic [1:0] KIND_DIRTY = 2'd2;
	localparam logic [1:0] KIND_DROP = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_PINNED = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef enum logic [1:0] {
		RK_INC_BELOW,
		RK_INC_ALL,
		RK_DEC_ABOVE
	} rank_op_t;
endpackage

// ----- hdl/lpb_rank_unit.sv -----
// Shared recency update unit: updates the rank of one frame per use
module lpb_rank_unit import lpb_pkg::*; (
	input  rank_op_t            op,
	input  logic [RANK_W-1:0]   rank_in,
	input  logic [RANK_W-1:0]   old_rank,
	input  logic                valid,
	input  logic                is_target,
	output logic [RANK_W-1:0]   rank_out
);
	always_comb begin
		rank_out = rank_in;
		if (is_target) begin
			rank_out = '0;
		end else if (valid) begin
			case (op)
				RK_INC_BELOW: if (rank_in < old_rank) rank_out = rank_in + 1'b1;
				RK_INC_ALL: rank_out = rank_in + 1'b1;
				RK_DEC_ABOVE: if (rank_in > old_rank) rank_out = rank_in - 1'b1;
				default: rank_out = rank_in;
			endcase
		end
	end
endmodule

// ----- hdl/lru_page_buffer_pool_unit.sv -----
// Page-frame table with LRU replacement, pin and dirty flags.
// Unpin and mark dirty: the flags update on accept and the result is registered in S_EMIT.
// Open: lookup scan over the enabled frames (up to 16) plus a recency sweep over all NUM_FRAMES
// frames through the shared rank unit; drop: a scan of the enabled frames plus a sweep per freed frame.
// One request at a time; the next is taken once the last result is registered.
// arst_n clears all frames to free and sets the frame count cfg_q to 16.
`include "lru_page_buffer_pool_unit_macros.svh"
module lru_page_buffer_pool_unit import lpb_pkg::*; #(
	parameter int NUM_FRAMES = 16,
	parameter int TABLE_BITS = 8,
	parameter int PAGE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_W-1:0]      cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            kind,
	input  logic [TABLE_BITS-1:0] table_ref,
	input  logic [PAGE_BITS-1:0]  page_number,
	input  logic [FRAME_W-1:0]    frame_index,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [FRAME_W-1:0]    frame_out,
	output logic                  hit,
	output logic                  need_load,
	output logic                  need_writeback,
	output logic [TABLE_BITS-1:0] old_table,
	output logic [PAGE_BITS-1:0]  old_page,
	output logic [1:0]            status,
	output logic                  last
);
	localparam int IW = $clog2(NUM_FRAMES);
	localparam int LIM = (NUM_FRAMES < ADDR_LIMIT) ? NUM_FRAMES : ADDR_LIMIT;
	localparam int CW = (IW > CFG_W) ? IW : CFG_W;

	typedef enum logic [3:0] {
		S_IDLE, S_LOOK, S_LDEC, S_RANK, S_FIN, S_DSCAN, S_DREL, S_DEND, S_EMIT
	} state_t;

	state_t state_q, ret_q;
	logic [CFG_W-1:0] cfg_q;
	logic [NUM_FRAMES-1:0] valid_q, pinned_q, dirty_q;
	logic [TABLE_BITS-1:0] tag_tab_q [NUM_FRAMES];
	logic [PAGE_BITS-1:0] tag_page_q [NUM_FRAMES];
	logic [RANK_W-1:0] rank_q [NUM_FRAMES];

	logic [TABLE_BITS-1:0] tab_q;
	logic [PAGE_BITS-1:0] page_q;
	logic [IW-1:0] sc_q, sw_q, f_q;
	logic [RANK_W-1:0] old_q;
	rank_op_t op_q;
	logic hit_q, wb_q;
	logic free_v_q, vic_v_q, vic_dirty_q;
	logic [IW-1:0] free_f_q, vic_f_q;
	logic [RANK_W-1:0] vic_rank_q;
	logic [TABLE_BITS-1:0] vic_tab_q;
	logic [PAGE_BITS-1:0] vic_page_q;
	logic pend_v_q;
	logic [IW-1:0] pend_f_q;
	logic [TABLE_BITS-1:0] pend_tab_q;
	logic [PAGE_BITS-1:0] pend_page_q;

	logic [FRAME_W-1:0] res_frame_q;
	logic res_hit_q, res_load_q, res_wb_q, res_last_q;
	logic [TABLE_BITS-1:0] res_tab_q;
	logic [PAGE_BITS-1:0] res_page_q;
	logic [1:0] res_status_q;

	logic out_valid_q;
	logic [FRAME_W-1:0] out_frame_q;
	logic out_hit_q, out_load_q, out_wb_q, out_last_q;
	logic [TABLE_BITS-1:0] out_tab_q;
	logic [PAGE_BITS-1:0] out_page_q;
	logic [1:0] out_status_q;

	logic [CFG_W-1:0] n_en, n_last;
	logic sweeping, sc_end, sw_end, tag_match;
	logic [IW-1:0] rd_addr, fi;
	logic [TABLE_BITS-1:0] tab_rd;
	logic [PAGE_BITS-1:0] page_rd;
	logic [RANK_W-1:0] rank_rd, rank_new;

	always_comb begin
		if (cfg_q == '0) n_en = CFG_W'(1);
		else if (cfg_q > CFG_W'(LIM)) n_en = CFG_W'(LIM);
		else n_en = cfg_q;
	end
	assign n_last = n_en - 1'b1;
	assign sweeping = (state_q == S_RANK) || (state_q == S_DREL);
	assign rd_addr = sweeping ? sw_q : sc_q;
	assign tab_rd = tag_tab_q[rd_addr];
	assign page_rd = tag_page_q[rd_addr];
	assign rank_rd = rank_q[rd_addr];
	assign sc_end = (CW'(sc_q) == CW'(n_last));
	assign sw_end = (sw_q == IW'(NUM_FRAMES - 1));
	assign tag_match = valid_q[sc_q] && (tab_rd == tab_q);
	assign fi = IW'(frame_index);

	lpb_rank_unit u_rank (
		.op        (op_q),
		.rank_in   (rank_rd),
		.old_rank  (old_q),
		.valid     (valid_q[sw_q]),
		.is_target (sw_q == f_q),
		.rank_out  (rank_new)
	);

	// tag and rank storage
	always_ff @(posedge clk) begin
		if (state_q == S_FIN && !hit_q) begin
			tag_tab_q[f_q] <= tab_q;
			tag_page_q[f_q] <= page_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FRAMES; i++) rank_q[i] <= '0;
		end else if (sweeping) begin
			rank_q[sw_q] <= rank_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			cfg_q <= CFG_W'(16);
			valid_q <= '0;
			pinned_q <= '0;
			dirty_q <= '0;
			out_valid_q <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (cfg_we) cfg_q <= cfg_wdata;
			if (out_valid_q && out_ready && state_q != S_EMIT) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) begin
					tab_q <= table_ref;
					page_q <= page_number;
					sc_q <= '0;
					sw_q <= '0;
					free_v_q <= 1'b0;
					vic_v_q <= 1'b0;
					hit_q <= 1'b0;
					wb_q <= 1'b0;
					pend_v_q <= 1'b0;
					res_frame_q <= frame_index;
					res_hit_q <= 1'b0;
					res_load_q <= 1'b0;
					res_wb_q <= 1'b0;
					res_tab_q <= '0;
					res_page_q <= '0;
					res_status_q <= (kind != KIND_OPEN && kind != KIND_DROP &&
						{1'b0, frame_index} >= n_en) ? ST_RANGE : ST_OK;
					res_last_q <= 1'b1;
					ret_q <= S_IDLE;
					case (kind)
						KIND_OPEN: state_q <= S_LOOK;
						KIND_DROP: state_q <= S_DSCAN;
						default: begin
							if ({1'b0, frame_index} < n_en) begin
								if (kind == KIND_UNPIN) pinned_q[fi] <= 1'b0;
								else if (valid_q[fi]) dirty_q[fi] <= 1'b1;
							end
							state_q <= S_EMIT;
						end
					endcase
				end
				S_LOOK: begin
					if (tag_match && page_rd == page_q) begin
						hit_q <= 1'b1;
						f_q <= sc_q;
						old_q <= rank_rd;
						op_q <= RK_INC_BELOW;
						state_q <= S_RANK;
					end else begin
						if (!valid_q[sc_q] && !free_v_q) begin
							free_v_q <= 1'b1;
							free_f_q <= sc_q;
						end
						if (!pinned_q[sc_q] && (!vic_v_q || rank_rd > vic_rank_q)) begin
							vic_v_q <= 1'b1;
							vic_f_q <= sc_q;
							vic_rank_q <= rank_rd;
							vic_dirty_q <= dirty_q[sc_q];
							vic_tab_q <= tab_rd;
							vic_page_q <= page_rd;
						end
						if (sc_end) state_q <= S_LDEC;
						else sc_q <= sc_q + 1'b1;
					end
				end
				S_LDEC: begin
					if (free_v_q) begin
						f_q <= free_f_q;
						op_q <= RK_INC_ALL;
						state_q <= S_RANK;
					end else if (vic_v_q) begin
						f_q <= vic_f_q;
						old_q <= vic_rank_q;
						op_q <= RK_INC_BELOW;
						wb_q <= vic_dirty_q;
						state_q <= S_RANK;
					end else begin
						res_frame_q <= '0;
						res_status_q <= ST_PINNED;
						state_q <= S_EMIT;
					end
				end
				S_RANK: begin
					if (sw_end) state_q <= S_FIN;
					else sw_q <= sw_q + 1'b1;
				end
				S_FIN: begin
					res_frame_q <= FRAME_W'(f_q);
					pinned_q[f_q] <= 1'b1;
					if (hit_q) begin
						res_hit_q <= 1'b1;
					end else begin
						valid_q[f_q] <= 1'b1;
						dirty_q[f_q] <= 1'b0;
						res_load_q <= 1'b1;
						res_wb_q <= wb_q;
						res_tab_q <= wb_q ? vic_tab_q : '0;
						res_page_q <= wb_q ? vic_page_q : '0;
					end
					state_q <= S_EMIT;
				end
				S_DSCAN: begin
					if (tag_match) begin
						f_q <= sc_q;
						old_q <= rank_rd;
						op_q <= RK_DEC_ABOVE;
						sw_q <= '0;
						if (dirty_q[sc_q]) begin
							// flush the previous write-back, hold this one
							pend_v_q <= 1'b1;
							pend_f_q <= sc_q;
							pend_tab_q <= tab_rd;
							pend_page_q <= page_rd;
						end
						if (dirty_q[sc_q] && pend_v_q) begin
							res_frame_q <= FRAME_W'(pend_f_q);
							res_wb_q <= 1'b1;
							res_tab_q <= pend_tab_q;
							res_page_q <= pend_page_q;
							res_last_q <= 1'b0;
							ret_q <= S_DREL;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_DREL;
						end
					end else if (sc_end) begin
						state_q <= S_DEND;
					end else begin
						sc_q <= sc_q + 1'b1;
					end
				end
				S_DREL: begin
					if (sw_end) begin
						valid_q[f_q] <= 1'b0;
						pinned_q[f_q] <= 1'b0;
						dirty_q[f_q] <= 1'b0;
						if (sc_end) state_q <= S_DEND;
						else begin
							sc_q <= sc_q + 1'b1;
							state_q <= S_DSCAN;
						end
					end else begin
						sw_q <= sw_q + 1'b1;
					end
				end
				S_DEND: begin
					res_last_q <= 1'b1;
					ret_q <= S_IDLE;
					if (pend_v_q) begin
						res_frame_q <= FRAME_W'(pend_f_q);
						res_wb_q <= 1'b1;
						res_tab_q <= pend_tab_q;
						res_page_q <= pend_page_q;
					end else begin
						res_frame_q <= '0;
						res_wb_q <= 1'b0;
						res_tab_q <= '0;
						res_page_q <= '0;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: if (!out_valid_q || out_ready) begin
					out_valid_q <= 1'b1;
					out_frame_q <= res_frame_q;
					out_hit_q <= res_hit_q;
					out_load_q <= res_load_q;
					out_wb_q <= res_wb_q;
					out_tab_q <= res_tab_q;
					out_page_q <= res_page_q;
					out_status_q <= res_status_q;
					out_last_q <= res_last_q;
					state_q <= ret_q;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign frame_out = out_frame_q;
	assign hit = out_hit_q;
	assign need_load = out_load_q;
	assign need_writeback = out_wb_q;
	assign old_table = out_tab_q;
	assign old_page = out_page_q;
	assign status = out_status_q;
	assign last = out_last_q;

	`LPB_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
	`LPB_ASSERT_NOW(a_pinned_alone, out_valid && status == ST_PINNED,
		last && !need_load && !hit && !need_writeback)
	`LPB_ASSERT_NOW(a_hit_no_load, out_valid && hit, !need_load && !need_writeback)
	`LPB_ASSERT_NOW(a_wb_has_tag_only, out_valid && !need_writeback,
		old_table == '0 && old_page == '0)
endmodule

// ----- test/lru_page_buffer_pool_unit_checker.sv -----
// Checker for the page buffer pool: predicts frame-table results and compares them
module lru_page_buffer_pool_unit_checker import lpb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  table_ref,
	input  logic [31:0] page_number,
	input  logic [3:0]  frame_index,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [3:0]  frame_out,
	input  logic        hit,
	input  logic        need_load,
	input  logic        need_writeback,
	input  logic [7:0]  old_table,
	input  logic [31:0] old_page,
	input  logic [1:0]  status,
	input  logic        last,
	output int          fail_count,
	output int          pending_results
);
	typedef struct packed {
		logic [3:0]  frame;
		logic        hit;
		logic        load;
		logic        wb;
		logic [7:0]  otab;
		logic [31:0] opage;
		logic [1:0]  st;
		logic        last;
	} page_result_t;

	page_result_t result_q[$];
	logic        fr_valid[16];
	logic [7:0]  fr_table[16];
	logic [31:0] fr_page[16];
	logic        fr_pinned[16];
	logic        fr_dirty[16];
	logic [4:0]  fr_age[16];
	logic [4:0]  frames_cfg;

	function automatic page_result_t mk(logic [3:0] f, logic h, logic ld, logic wb,
			logic [7:0] ot, logic [31:0] op, logic [1:0] st, logic l);
		page_result_t r;
		r.frame = f; r.hit = h; r.load = ld; r.wb = wb;
		r.otab = ot; r.opage = op; r.st = st; r.last = l;
		return r;
	endfunction

	task automatic make_recent(int f);
		logic [4:0] a;
		a = fr_age[f];
		for (int i = 0; i < 16; i++)
			if (fr_valid[i] && i != f && fr_age[i] < a) fr_age[i]++;
		fr_age[f] = 0;
	endtask

	task automatic add_recent(int f);
		for (int i = 0; i < 16; i++)
			if (fr_valid[i]) fr_age[i]++;
		fr_valid[f] = 1;
		fr_age[f] = 0;
	endtask

	task automatic free_frame(int f);
		logic [4:0] a;
		a = fr_age[f];
		for (int i = 0; i < 16; i++)
			if (fr_valid[i] && i != f && fr_age[i] > a) fr_age[i]--;
		fr_valid[f] = 0; fr_pinned[f] = 0; fr_dirty[f] = 0; fr_age[f] = 0;
	endtask

	task automatic predict_request(logic [1:0] k, logic [7:0] tb, logic [31:0] pg,
			logic [3:0] fi);
		int n, f, cnt;
		bit found;
		page_result_t r;
		n = frames_cfg < 1 ? 1 : (frames_cfg > 16 ? 16 : frames_cfg);
		found = 0; f = 0; cnt = 0;
		if (k == KIND_OPEN) begin
			for (int i = 0; i < n; i++)
				if (!found && fr_valid[i] && fr_table[i] == tb && fr_page[i] == pg) begin
					found = 1; f = i;
				end
			if (found) begin
				fr_pinned[f] = 1;
				make_recent(f);
				result_q.push_back(mk(f, 1, 0, 0, 0, 0, ST_OK, 1));
				return;
			end
			for (int i = 0; i < n; i++)
				if (!found && !fr_valid[i]) begin
					found = 1; f = i;
				end
			if (found) begin
				add_recent(f);
				fr_table[f] = tb; fr_page[f] = pg; fr_pinned[f] = 1; fr_dirty[f] = 0;
				result_q.push_back(mk(f, 0, 1, 0, 0, 0, ST_OK, 1));
				return;
			end
			for (int i = 0; i < n; i++)
				if (!fr_pinned[i] && (!found || fr_age[i] > fr_age[f])) begin
					f = i; found = 1;
				end
			if (!found) begin
				result_q.push_back(mk(0, 0, 0, 0, 0, 0, ST_PINNED, 1));
				return;
			end
			if (fr_dirty[f]) r = mk(f, 0, 1, 1, fr_table[f], fr_page[f], ST_OK, 1);
			else r = mk(f, 0, 1, 0, 0, 0, ST_OK, 1);
			make_recent(f);
			fr_table[f] = tb; fr_page[f] = pg; fr_pinned[f] = 1; fr_dirty[f] = 0;
			result_q.push_back(r);
		end else if (k == KIND_UNPIN || k == KIND_DIRTY) begin
			if (fi >= n) begin
				result_q.push_back(mk(fi, 0, 0, 0, 0, 0, ST_RANGE, 1));
				return;
			end
			if (k == KIND_UNPIN) fr_pinned[fi] = 0;
			else if (fr_valid[fi]) fr_dirty[fi] = 1;
			result_q.push_back(mk(fi, 0, 0, 0, 0, 0, ST_OK, 1));
		end else begin
			for (int i = 0; i < n; i++) begin
				if (fr_valid[i] && fr_table[i] == tb) begin
					if (fr_dirty[i]) begin
						result_q.push_back(mk(i, 0, 0, 1, fr_table[i], fr_page[i], ST_OK, 0));
						cnt++;
					end
					free_frame(i);
				end
			end
			if (cnt == 0) result_q.push_back(mk(0, 0, 0, 0, 0, 0, ST_OK, 1));
			else result_q[$].last = 1;
		end
	endtask

	assign pending_results = result_q.size();

	always @(posedge clk or negedge arst_n) begin
		page_result_t got, want;
		if (!arst_n) begin
			result_q.delete();
			fail_count <= 0;
			frames_cfg = 5'd16;
			for (int i = 0; i < 16; i++) begin
				fr_valid[i] = 0; fr_table[i] = 0; fr_page[i] = 0;
				fr_pinned[i] = 0; fr_dirty[i] = 0; fr_age[i] = 0;
			end
		end else begin
			if (out_valid && out_ready) begin
				got = mk(frame_out, hit, need_load, need_writeback, old_table, old_page,
					status, last);
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result beat %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = result_q.pop_front();
					if (got !== want) begin
						$display("%0t: result mismatch expected %h actual %h", $time, want, got);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready) predict_request(kind, table_ref, page_number, frame_index);
			if (cfg_we) frames_cfg = cfg_wdata;
		end
	end
endmodule

// ----- test/lru_page_buffer_pool_unit_tb.sv -----
// Stimulus and verdict for the page buffer pool
module lru_page_buffer_pool_unit_tb import lpb_pkg::*;;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [4:0]  cfg_wdata = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [1:0]  kind = 0;
	logic [7:0]  table_ref = 0;
	logic [31:0] page_number = 0;
	logic [3:0]  frame_index = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [3:0]  frame_out;
	logic        hit, need_load, need_writeback, last;
	logic [7:0]  old_table;
	logic [31:0] old_page;
	logic [1:0]  status;
	int          fail_count, pending_results;
	int          send_idle_pct = 0, recv_stall_pct = 0;
	bit          hold_off = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	lru_page_buffer_pool_unit u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind), .table_ref(table_ref),
		.page_number(page_number), .frame_index(frame_index), .out_valid(out_valid),
		.out_ready(out_ready), .frame_out(frame_out), .hit(hit), .need_load(need_load),
		.need_writeback(need_writeback), .old_table(old_table), .old_page(old_page),
		.status(status), .last(last)
	);

	lru_page_buffer_pool_unit_checker u_check (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind), .table_ref(table_ref),
		.page_number(page_number), .frame_index(frame_index), .out_valid(out_valid),
		.out_ready(out_ready), .frame_out(frame_out), .hit(hit), .need_load(need_load),
		.need_writeback(need_writeback), .old_table(old_table), .old_page(old_page),
		.status(status), .last(last), .fail_count(fail_count),
		.pending_results(pending_results)
	);

	// receiver: random stall, or hold off entirely during the pressure stretch
	always @(posedge clk) begin
		out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_beat(logic [1:0] k, logic [7:0] tb, logic [31:0] pg, logic [3:0] fi);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1; kind <= k; table_ref <= tb; page_number <= pg; frame_index <= fi;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic write_frames(logic [4:0] v);
		in_valid <= 0;
		while (pending_results != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		cfg_we <= 1; cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_beat(int ntab, int npage);
		int r;
		logic [31:0] pg;
		r = $urandom_range(99);
		pg = ($urandom_range(9) == 0) ? $urandom : $urandom_range(npage - 1);
		if (r < 50) send_beat(KIND_OPEN, $urandom_range(ntab - 1), pg, 0);
		else if (r < 70) send_beat(KIND_UNPIN, 0, 0, $urandom);
		else if (r < 85) send_beat(KIND_DIRTY, 0, 0, $urandom);
		else if (r < 95) send_beat(KIND_DROP, $urandom_range(ntab - 1), 0, 0);
		else send_beat($urandom, $urandom, $urandom, $urandom);
	endtask

	initial begin
		#2000000;
		$display("[lru_page_buffer_pool_unit] ERROR");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: fill, hit, dirty, evict, all pinned, out of range, drop
		for (int i = 0; i < 16; i++) send_beat(KIND_OPEN, 8'd1, i, 0);
		send_beat(KIND_OPEN, 8'd1, 32'd3, 0);
		send_beat(KIND_OPEN, 8'hFF, 32'hFFFF_FFFF, 0);
		send_beat(KIND_DIRTY, 0, 0, 4'd5);
		send_beat(KIND_UNPIN, 0, 0, 4'd5);
		send_beat(KIND_UNPIN, 0, 0, 4'd15);
		send_beat(KIND_OPEN, 8'hFF, 32'hFFFF_FFFF, 0);
		send_beat(KIND_DROP, 8'd1, 0, 0);
		send_beat(KIND_DROP, 8'd0, 0, 0);
		write_frames(5'd1);
		send_beat(KIND_UNPIN, 0, 0, 4'd1);
		send_beat(KIND_DIRTY, 0, 0, 4'd0);
		write_frames(5'd0);
		send_beat(KIND_OPEN, 8'd2, 32'd7, 0);
		write_frames(5'd31);
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
				3: begin send_idle_pct = 14; recv_stall_pct = 14; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			if (ph == 1) write_frames(5'd4);
			if (ph == 2) write_frames(5'd16);
			if (ph == 3) write_frames(5'd2);
			if (ph == 4) write_frames(5'd9);
			if (ph == 4) begin
				fork
					begin
						hold_off = 1;
						for (int c = 0; c < 300; c++) @(posedge clk);
						hold_off = 0;
					end
				join_none
			end
			for (int i = 0; i < 72; i++) random_beat(ph == 3 ? 2 : 4, 12);
		end
		in_valid <= 0;
		while (pending_results != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		if (fail_count == 0) $display("[lru_page_buffer_pool_unit] OK");
		else $display("[lru_page_buffer_pool_unit] ERROR");
		$finish;
	end
endmodule
